/* rtl/core/sfd_pkg.sv */
// Shared types and constants of the stereo feedback delay core.
package sfd_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int GAIN_BITS     = 15;
    localparam int DELAY_BITS    = 17;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;
    localparam int Q_SHIFT       = 15;

    localparam logic [GAIN_BITS-1:0]  GAIN_LEFT_RST   = 15'd9830;
    localparam logic [GAIN_BITS-1:0]  GAIN_RIGHT_RST  = 15'd9830;
    localparam logic [DELAY_BITS-1:0] DELAY_LEFT_RST  = 17'd35280;
    localparam logic [DELAY_BITS-1:0] DELAY_RIGHT_RST = 17'd44100;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN_LEFT   = 2'd0,
        CFG_GAIN_RIGHT  = 2'd1,
        CFG_DELAY_LEFT  = 2'd2,
        CFG_DELAY_RIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_left;
        logic signed [SAMPLE_BITS-1:0] in_right;
    } t_in_frame;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } t_out_frame;

endpackage

/* rtl/core/sfd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read and write to one entry on the same edge returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sfd_offset_mod.sv */
// Two-stage reduction of a delay offset modulo the store depth.
module sfd_offset_mod
    import sfd_pkg::*;
#(
    parameter int DEPTH = 131072
) (
    input  logic                     i_clk,
    input  logic [DELAY_BITS-1:0]    i_value,
    output logic [$clog2(DEPTH)-1:0] o_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int S  = DELAY_BITS + AW;
    localparam int PW = S + DELAY_BITS;
    localparam int QW = DELAY_BITS + AW + 1;
    localparam int RW = ((DELAY_BITS > AW) ? DELAY_BITS : AW) + 1;
    localparam logic [63:0] RECIP = (64'd1 << S) / 64'(DEPTH);

    logic [PW-1:0]         prod;
    logic [DELAY_BITS-1:0] r_x;
    logic [DELAY_BITS-1:0] r_q;
    logic [QW-1:0]         qd;
    logic [DELAY_BITS-1:0] rem0;
    logic [RW-1:0]         rem_ext;
    logic [RW-1:0]         rem_fix;
    logic [AW-1:0]         r_res;

    // quotient estimate, low by at most one
    assign prod = PW'(i_value) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        r_x <= i_value;
        r_q <= prod[PW-1:S];
    end

    assign qd      = QW'(r_q) * QW'(DEPTH);
    assign rem0    = r_x - qd[DELAY_BITS-1:0];
    assign rem_ext = RW'(rem0);
    assign rem_fix = (rem_ext >= RW'(DEPTH)) ? (rem_ext - RW'(DEPTH)) : rem_ext;

    always_ff @(posedge i_clk) begin
        r_res <= rem_fix[AW-1:0];
    end

    assign o_value = r_res;

endmodule

/* rtl/core/stereo_feedback_delay_core.sv */
// Top level of the stereo feedback delay (echo) core.
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  -------------------------
//  in        sink       i_in_valid / o_in_ready   i_in  (t_in_frame)
//  out       source     o_out_valid / i_out_ready o_out (t_out_frame)
//  cfg       sink       i_cfg_we (no wait)        i_cfg_addr, i_cfg_data
//
//  A new frame is accepted only once the previous one has left the read
//  stage: the store entries are read on the accept edge, summed and
//  saturated in the next cycle, the frame enters its output register when
//  that register can take it, and the scaled feedback is written back in the
//  cycle after, while the next frame reads. After reset both stores are swept
//  to zero, all entries, one per cycle on both together; no frame is taken
//  meanwhile, configuration writes are. A stalled output holds the one frame
//  in flight; input stays blocked until the output register can take it.
module stereo_feedback_delay_core
    import sfd_pkg::*;
#(
    parameter int STORE_DEPTH = 131072
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_frame                i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_frame               o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int SB = SAMPLE_BITS;
    localparam int PB = SB + GAIN_BITS + 1;
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
    localparam logic signed [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [GAIN_BITS-1:0]  r_gain_l;
    logic [GAIN_BITS-1:0]  r_gain_r;
    logic [DELAY_BITS-1:0] r_delay_l;
    logic [DELAY_BITS-1:0] r_delay_r;
    logic [AW-1:0]         delay_l_mod;
    logic [AW-1:0]         delay_r_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_l  <= GAIN_LEFT_RST;
            r_gain_r  <= GAIN_RIGHT_RST;
            r_delay_l <= DELAY_LEFT_RST;
            r_delay_r <= DELAY_RIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_GAIN_LEFT:   r_gain_l  <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_RIGHT:  r_gain_r  <= i_cfg_data[GAIN_BITS-1:0];
                CFG_DELAY_LEFT:  r_delay_l <= i_cfg_data[DELAY_BITS-1:0];
                CFG_DELAY_RIGHT: r_delay_r <= i_cfg_data[DELAY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Offsets reduced modulo the depth through the registered reducer stages;
    // settled in time for the write-back of a frame accepted after the write.
    sfd_offset_mod #(.DEPTH(STORE_DEPTH)) u_mod_l (
        .i_clk   (i_clk),
        .i_value (r_delay_l),
        .o_value (delay_l_mod)
    );

    sfd_offset_mod #(.DEPTH(STORE_DEPTH)) u_mod_r (
        .i_clk   (i_clk),
        .i_value (r_delay_r),
        .o_value (delay_r_mod)
    );

    // ---------------------------------------------------------------
    // Clearing sweep after reset
    // ---------------------------------------------------------------
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Handshake and position
    // ---------------------------------------------------------------
    logic          r_a_valid;
    logic          r_out_valid;
    logic          accept;
    logic          advance;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] n_pos;
    logic [AW:0]   pos_p1;
    logic [AW:0]   pos_p2;
    logic [AW-1:0] rd_addr_l;
    logic [AW-1:0] rd_addr_r;

    assign o_in_ready = ~r_a_valid & ~r_clr_active;
    assign accept     = i_in_valid & o_in_ready;
    assign advance    = r_a_valid & (~r_out_valid | i_out_ready);

    // left reads at the position, right one entry further on
    assign pos_p1    = (AW+1)'(r_pos) + (AW+1)'(1);
    assign pos_p2    = (AW+1)'(r_pos) + (AW+1)'(2);
    assign rd_addr_l = r_pos;
    assign rd_addr_r = (pos_p1 >= DEPTH_EXT) ? AW'(pos_p1 - DEPTH_EXT) : pos_p1[AW-1:0];
    assign n_pos     = (pos_p2 >= DEPTH_EXT) ? AW'(pos_p2 - DEPTH_EXT) : pos_p2[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
        end
    end

    // ---------------------------------------------------------------
    // Write-back stage: scale the saturated output and store it ahead
    // ---------------------------------------------------------------
    logic                 r_w_valid;
    logic [AW-1:0]        r_w_pos;
    logic signed [SB-1:0] r_w_sat_l;
    logic signed [SB-1:0] r_w_sat_r;
    logic [AW:0]          w_sum_l;
    logic [AW:0]          w_sum_r;
    logic [AW-1:0]        w_addr_l;
    logic [AW-1:0]        w_addr_r;
    logic signed [PB-1:0] prod_l;
    logic signed [PB-1:0] prod_r;
    logic [SB-1:0]        w_data_l;
    logic [SB-1:0]        w_data_r;

    assign w_sum_l  = (AW+1)'(r_w_pos) + (AW+1)'(delay_l_mod);
    assign w_sum_r  = (AW+1)'(r_w_pos) + (AW+1)'(delay_r_mod) + (AW+1)'(1);
    assign w_addr_l = (w_sum_l >= DEPTH_EXT) ? AW'(w_sum_l - DEPTH_EXT) : w_sum_l[AW-1:0];
    assign w_addr_r = (w_sum_r >= DEPTH_EXT) ? AW'(w_sum_r - DEPTH_EXT) : w_sum_r[AW-1:0];

    // unsigned Q0.15 gain, arithmetic shift gives floor rounding
    assign prod_l   = PB'(r_w_sat_l) * PB'($signed({1'b0, r_gain_l}));
    assign prod_r   = PB'(r_w_sat_r) * PB'($signed({1'b0, r_gain_r}));
    assign w_data_l = prod_l[Q_SHIFT +: SB];
    assign w_data_r = prod_r[Q_SHIFT +: SB];

    // ---------------------------------------------------------------
    // Store memories; the sweep owns the write port until it ends
    // ---------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr_l;
    logic [AW-1:0] ram_waddr_r;
    logic [SB-1:0] ram_wdata_l;
    logic [SB-1:0] ram_wdata_r;
    logic [SB-1:0] ram_rdata_l;
    logic [SB-1:0] ram_rdata_r;

    assign ram_we      = r_clr_active | r_w_valid;
    assign ram_waddr_l = r_clr_active ? r_clr_addr : w_addr_l;
    assign ram_waddr_r = r_clr_active ? r_clr_addr : w_addr_r;
    assign ram_wdata_l = r_clr_active ? '0 : w_data_l;
    assign ram_wdata_r = r_clr_active ? '0 : w_data_r;

    sfd_ram #(.WIDTH(SB), .DEPTH(STORE_DEPTH)) u_store_l (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr_l),
        .i_wdata (ram_wdata_l),
        .i_re    (accept),
        .i_raddr (rd_addr_l),
        .o_rdata (ram_rdata_l)
    );

    sfd_ram #(.WIDTH(SB), .DEPTH(STORE_DEPTH)) u_store_r (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr_r),
        .i_wdata (ram_wdata_r),
        .i_re    (accept),
        .i_raddr (rd_addr_r),
        .o_rdata (ram_rdata_r)
    );

    // ---------------------------------------------------------------
    // Read stage: the previous frame's write-back may land on the entry
    // read on this same edge; forward it, as the RAM returns old data.
    // ---------------------------------------------------------------
    t_in_frame     r_a_in;
    logic [AW-1:0] r_a_pos;
    logic          r_fwd_l;
    logic          r_fwd_r;
    logic [SB-1:0] r_fwd_data_l;
    logic [SB-1:0] r_fwd_data_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_in       <= i_in;
            r_a_pos      <= r_pos;
            r_fwd_l      <= r_w_valid & (w_addr_l == rd_addr_l);
            r_fwd_r      <= r_w_valid & (w_addr_r == rd_addr_r);
            r_fwd_data_l <= w_data_l;
            r_fwd_data_r <= w_data_r;
        end
    end

    logic signed [SB-1:0] fb_l;
    logic signed [SB-1:0] fb_r;
    logic signed [SB:0]   sum_l;
    logic signed [SB:0]   sum_r;
    logic signed [SB-1:0] sat_l;
    logic signed [SB-1:0] sat_r;

    assign fb_l  = r_fwd_l ? r_fwd_data_l : ram_rdata_l;
    assign fb_r  = r_fwd_r ? r_fwd_data_r : ram_rdata_r;
    assign sum_l = (SB+1)'(r_a_in.in_left) + (SB+1)'(fb_l);
    assign sum_r = (SB+1)'(r_a_in.in_right) + (SB+1)'(fb_r);

    // clamp where the top two bits of the sum disagree
    always_comb begin
        if (sum_l[SB] != sum_l[SB-1]) begin
            sat_l = sum_l[SB] ? SAT_MIN : SAT_MAX;
        end else begin
            sat_l = sum_l[SB-1:0];
        end
        if (sum_r[SB] != sum_r[SB-1]) begin
            sat_r = sum_r[SB] ? SAT_MIN : SAT_MAX;
        end else begin
            sat_r = sum_r[SB-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Output register and write-back stage loading
    // ---------------------------------------------------------------
    t_out_frame r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_w_valid   <= 1'b0;
        end else begin
            r_w_valid <= advance;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.out_left  <= sat_l;
            r_out.out_right <= sat_r;
            r_w_pos         <= r_a_pos;
            r_w_sat_l       <= sat_l;
            r_w_sat_r       <= sat_r;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
